@@ rtl/lniw_pkg.sv @@
// Shared types and constants for the LCD nibble writer over an I2C expander.
// Used by lniw_front, lniw_queue, lniw_back and lcd_nibble_i2c_writer.
`timescale 1ns / 1ps
package lniw_pkg;

   localparam int unsigned QueueDepthDefault = 2;

   localparam int unsigned FrameBytes = 5;
   localparam int unsigned FrameBits  = 8 * FrameBytes;

   typedef logic [FrameBits-1:0] frame_type;

   typedef enum logic [0:0] {
      CSR_DEVICE_ADDRESS = 1'b0,
      CSR_BACKLIGHT_ON   = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      EV_START = 2'd0,
      EV_CLOCK = 2'd1,
      EV_STOP  = 2'd2
   } event_kind_type;

   localparam logic [6:0] DeviceAddressReset = 7'd39;
   localparam logic       BacklightReset     = 1'b1;

   localparam logic [7:0] EnableBit    = 8'h04;
   localparam logic [7:0] BacklightBit = 8'h08;

   typedef struct packed {
      logic      valid;
      frame_type frame;
   } queue_head_type;

endpackage

@@ rtl/lniw_front.sv @@
// Front end: configuration registers and input word accept; builds the five
// bus bytes of one write. Depends on lniw_pkg.
`timescale 1ns / 1ps
module lniw_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  lniw_pkg::csr_index_type csr_index,
   input  logic [6:0]             csr_data,
   input  logic                   push,
   output logic                   full,
   input  logic                   req_command,
   input  logic [7:0]             req_byte_value,
   input  logic                   q_full,
   output logic                   q_push,
   output lniw_pkg::frame_type    q_frame
);
   import lniw_pkg::*;

   logic [6:0] dev_addr_ff, dev_addr_in;
   logic       backlight_ff, backlight_in;
   logic [7:0] base;
   logic [7:0] hi_nib;
   logic [7:0] lo_nib;

   assign csr_ready = 1'b1;

   always_comb begin
      dev_addr_in  = dev_addr_ff;
      backlight_in = backlight_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_DEVICE_ADDRESS: dev_addr_in  = csr_data;
            CSR_BACKLIGHT_ON:   backlight_in = csr_data[0];
            default:            dev_addr_in  = dev_addr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff  <= DeviceAddressReset;
         backlight_ff <= BacklightReset;
      end else begin
         dev_addr_ff  <= dev_addr_in;
         backlight_ff <= backlight_in;
      end
   end

   assign full   = q_full;
   assign q_push = push & ~q_full;

   assign base   = (backlight_ff ? BacklightBit : 8'h00) | {7'd0, req_command};
   assign hi_nib = {req_byte_value[7:4], 4'h0};
   assign lo_nib = {req_byte_value[3:0], 4'h0};

   assign q_frame = {dev_addr_ff, 1'b0,
                     hi_nib | base | EnableBit,
                     hi_nib | base,
                     lo_nib | base | EnableBit,
                     lo_nib | base};

endmodule

@@ rtl/lniw_queue.sv @@
// Short frame queue between front and back ends.
// Depends on lniw_pkg.
`timescale 1ns / 1ps
module lniw_queue #(
   parameter int unsigned QUEUE_DEPTH = lniw_pkg::QueueDepthDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  lniw_pkg::frame_type      wr_frame,
   output logic                     is_full,
   input  logic                     rd_en,
   output lniw_pkg::queue_head_type head
);
   import lniw_pkg::*;

   localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);
   localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);

   frame_type       mem [QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_wr;
   logic            do_rd;

   assign is_full = (count_ff == CntFull);
   assign do_wr   = wr_en & ~is_full;
   assign do_rd   = rd_en & (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.frame = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem[wr_ptr_ff] <= wr_frame;
      end
   end

endmodule

@@ rtl/lniw_back.sv @@
// Back end: bus event sequencer with registered output word.
// Depends on lniw_pkg.
`timescale 1ns / 1ps
module lniw_back (
   input  logic                     clock,
   input  logic                     reset,
   input  lniw_pkg::queue_head_type head,
   output logic                     q_pop,
   output logic                     empty,
   input  logic                     pop,
   output logic [1:0]               rsp_event_kind,
   output logic                     rsp_sda_level,
   output logic                     rsp_last
);
   import lniw_pkg::*;

   typedef enum logic [2:0] {
      ST_START = 3'b001,
      ST_BITS  = 3'b010,
      ST_STOP  = 3'b100
   } state_type;

   state_type      state_ff, state_in;
   frame_type      shift_ff, shift_in;
   logic [3:0]     bit_ff, bit_in;
   logic [2:0]     byte_ff, byte_in;
   logic           valid_ff, valid_in;
   event_kind_type kind_ff, kind_in;
   logic           sda_ff, sda_in;
   logic           last_ff, last_in;
   logic           adv;
   logic           emit;

   assign adv = ~valid_ff | pop;

   always_comb begin
      state_in = state_ff;
      shift_in = shift_ff;
      bit_in   = bit_ff;
      byte_in  = byte_ff;
      kind_in  = kind_ff;
      sda_in   = sda_ff;
      last_in  = last_ff;
      emit     = 1'b0;
      q_pop    = 1'b0;
      if (adv) begin
         unique case (state_ff)
            ST_START: begin
               if (head.valid) begin
                  emit     = 1'b1;
                  kind_in  = EV_START;
                  sda_in   = 1'b0;
                  last_in  = 1'b0;
                  shift_in = head.frame;
                  bit_in   = '0;
                  byte_in  = '0;
                  q_pop    = 1'b1;
                  state_in = ST_BITS;
               end
            end
            ST_BITS: begin
               emit    = 1'b1;
               kind_in = EV_CLOCK;
               last_in = 1'b0;
               if (bit_ff == 4'd8) begin
                  sda_in = 1'b1;
                  bit_in = '0;
                  if (byte_ff == 3'(FrameBytes - 1)) begin
                     state_in = ST_STOP;
                  end else begin
                     byte_in = byte_ff + 1'b1;
                  end
               end else begin
                  sda_in   = shift_ff[FrameBits-1];
                  shift_in = {shift_ff[FrameBits-2:0], 1'b0};
                  bit_in   = bit_ff + 1'b1;
               end
            end
            ST_STOP: begin
               emit     = 1'b1;
               kind_in  = EV_STOP;
               sda_in   = 1'b0;
               last_in  = 1'b1;
               state_in = ST_START;
            end
            default: state_in = ST_START;
         endcase
      end
   end

   always_comb begin
      priority if (emit) begin
         valid_in = 1'b1;
      end else if (pop) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_START;
         valid_ff <= 1'b0;
         bit_ff   <= '0;
         byte_ff  <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         bit_ff   <= bit_in;
         byte_ff  <= byte_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      kind_ff  <= kind_in;
      sda_ff   <= sda_in;
      last_ff  <= last_in;
   end

   assign empty          = ~valid_ff;
   assign rsp_event_kind = kind_ff;
   assign rsp_sda_level  = sda_ff;
   assign rsp_last       = last_ff;

endmodule

@@ rtl/lcd_nibble_i2c_writer.sv @@
// channel  | handshake                | payload
// request  | push / full              | req_command, req_byte_value
// response | empty / pop              | rsp_event_kind, rsp_sda_level, rsp_last
// csr      | csr_valid / csr_ready    | csr_index, csr_data
//
// One write yields 47 bus events, one per cycle from the back-end sequencer
// while pop keeps up; a queued next write's start follows the previous stop directly.
// The frame queue lets the front accept QUEUE_DEPTH writes ahead of the back end.
// Synchronous reset clears queue, sequencer and output valid; csr reset to 39 and 1.
// Depends on lniw_pkg, lniw_front, lniw_queue, lniw_back.
`timescale 1ns / 1ps
module lcd_nibble_i2c_writer #(
   parameter int unsigned QUEUE_DEPTH = lniw_pkg::QueueDepthDefault
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  lniw_pkg::csr_index_type csr_index,
   input  logic [6:0]              csr_data,
   input  logic                    push,
   output logic                    full,
   input  logic                    req_command,
   input  logic [7:0]              req_byte_value,
   output logic                    empty,
   input  logic                    pop,
   output logic [1:0]              rsp_event_kind,
   output logic                    rsp_sda_level,
   output logic                    rsp_last
);
   import lniw_pkg::*;

   logic           q_full;
   logic           q_push;
   frame_type      q_frame;
   logic           q_pop;
   queue_head_type q_head;

   lniw_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .push           (push),
      .full           (full),
      .req_command    (req_command),
      .req_byte_value (req_byte_value),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_frame        (q_frame)
   );

   lniw_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (q_push),
      .wr_frame (q_frame),
      .is_full  (q_full),
      .rd_en    (q_pop),
      .head     (q_head)
   );

   lniw_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (q_head),
      .q_pop          (q_pop),
      .empty          (empty),
      .pop            (pop),
      .rsp_event_kind (rsp_event_kind),
      .rsp_sda_level  (rsp_sda_level),
      .rsp_last       (rsp_last)
   );

endmodule
